### hw/rtl/pvm_pkg.sv
`timescale 1ns / 1ps
package pvm_pkg;
   localparam int CLIP_SLOTS = 64;
   localparam int VOICES     = 8;
   localparam int MAX_FRAMES = 1024;

   localparam int CLIP_W  = 7;
   localparam int GAIN_W  = 8;
   localparam int SMP_W   = 16;
   localparam int OP_W    = 3;
   localparam int SLOT_W  = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
   localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int STORE_DEPTH = CLIP_SLOTS * MAX_FRAMES;
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int PROD_W  = SMP_W + GAIN_W + 1;
   localparam int ABS_W   = PROD_W - 1;
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = 27;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);
   localparam int QUOT_W  = 18;
   localparam int ACC_W   = QUOT_W + 2 + $clog2(VOICES + 1);

   localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(200);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

   typedef enum logic [OP_W-1:0] {
      OP_MIX        = 3'd0,
      OP_LOAD       = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_PLAY       = 3'd3,
      OP_PLAY_LOOP  = 3'd4,
      OP_STOP_LOOP  = 3'd5,
      OP_STOP_ALL   = 3'd6,
      OP_NONE       = 3'd7
   } op_type;
endpackage

### hw/rtl/pvm_if.sv
`timescale 1ns / 1ps
interface pvm_req_if import pvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [CLIP_W-1:0]        clip;
   logic [GAIN_W-1:0]        gain;
   logic signed [SMP_W-1:0]  sample;
   logic                     last;
   modport source (output valid, operation, clip, gain, sample, last, input ready);
   modport sink (input valid, operation, clip, gain, sample, last, output ready);
endinterface

interface pvm_rsp_if import pvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SMP_W-1:0]  mixed;
   logic [CLIP_W-1:0]        clip_id;
   logic                     ok;
   modport source (output valid, mixed, clip_id, ok, input ready);
   modport sink (input valid, mixed, clip_id, ok, output ready);
endinterface

### hw/rtl/pvm_ram.sv
`timescale 1ns / 1ps
module pvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hw/rtl/pcm_voice_mixer.sv
`timescale 1ns / 1ps
// Clip store and eight-voice mixer. Every operation but mix answers in the cycle after the
// request is taken. A mix walks the voices one at a time through the sample and length
// memories (a read, a multiply, a reciprocal divide, an accumulate): an idle voice is
// skipped in ST_READ, an active voice passes ST_READ, ST_CHECK, ST_DIV and ST_ACC, and
// ST_DONE delivers once the response register is free. Samples live in a 64 x 1024 word
// memory; slot occupancy is kept in flip-flops cleared by reset, so no clearing pass is needed.
module pcm_voice_mixer import pvm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pvm_req_if.sink    req_channel,
   pvm_rsp_if.source  rsp_channel
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CLIP_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [CLIP_W-1:0] voice_clip_ff [VOICES], voice_clip_in [VOICES];
   logic [LEN_W-1:0]  voice_pos_ff [VOICES], voice_pos_in [VOICES];
   logic [GAIN_W-1:0] voice_gain_ff [VOICES], voice_gain_in [VOICES];
   logic [VOICES-1:0] voice_loops_ff, voice_loops_in;
   logic [VOICE_W-1:0] cursor_ff, cursor_in;
   logic [CLIP_W-1:0] load_slot_ff, load_slot_in;
   logic [LEN_W-1:0]  load_count_ff, load_count_in;
   logic load_failed_ff, load_failed_in;
   logic [VOICE_W-1:0] vidx_ff, vidx_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [ABS_W+RECIP_W-1:0] scaled_ff, scaled_in;
   logic neg_ff, neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0] rsp_mixed_ff, rsp_mixed_in;
   logic [CLIP_W-1:0] rsp_id_ff, rsp_id_in;
   logic rsp_ok_ff, rsp_ok_in;

   logic st_we, len_we;
   logic [ADDR_W-1:0] st_waddr, st_raddr;
   logic [SMP_W-1:0] st_wdata, st_rdata;
   logic [SLOT_W-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0] len_wdata, len_rdata;

   pvm_ram #(.WIDTH(SMP_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   pvm_ram #(.WIDTH(LEN_W), .DEPTH(CLIP_SLOTS)) u_length (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_addr(len_raddr), .rd_data(len_rdata)
   );

   function automatic logic clip_ok(logic [CLIP_W-1:0] c, logic [CLIP_SLOTS-1:0] vb);
      logic [CLIP_W-1:0] cm;
      cm = c - CLIP_W'(1);
      return (c != '0) && (int'(c) <= CLIP_SLOTS) && vb[cm[SLOT_W-1:0]];
   endfunction

   logic accept, rsp_free;
   logic [GAIN_W-1:0] gain_c;
   logic [CLIP_W-1:0] cm1;
   logic free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [CLIP_W-1:0] slot_eff, slot_m1;
   logic [LEN_W-1:0] cnt_eff;
   logic fail_eff;
   logic loop_hit, voice_free;
   logic [VOICE_W-1:0] loop_v, free_v, take_v;
   logic signed [ACC_W-1:0] quot_s;
   logic [ABS_W-1:0] prod_abs;
   logic [LEN_W-1:0] pos_next;

   assign rsp_free = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept = req_channel.valid && req_channel.ready;
   assign gain_c = (req_channel.gain > GAIN_MAX) ? GAIN_MAX : req_channel.gain;
   assign cm1 = req_channel.clip - CLIP_W'(1);
   assign prod_abs = prod_ff[PROD_W-1] ? ABS_W'(-prod_ff) : ABS_W'(prod_ff);
   assign quot_s = neg_ff ? -ACC_W'(scaled_ff[ABS_W+RECIP_W-1:RECIP_SH])
                          : ACC_W'(scaled_ff[ABS_W+RECIP_W-1:RECIP_SH]);
   assign pos_next = voice_pos_ff[vidx_ff] + LEN_W'(1);

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = CLIP_SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
      loop_hit = 1'b0;
      loop_v = '0;
      voice_free = 1'b0;
      free_v = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (voice_clip_ff[v] == req_channel.clip && voice_loops_ff[v]) begin
            loop_hit = 1'b1;
            loop_v = VOICE_W'(v);
         end
         if (voice_clip_ff[v] == '0) begin
            voice_free = 1'b1;
            free_v = VOICE_W'(v);
         end
      end
      take_v = voice_free ? free_v : cursor_ff;
   end

   always_comb begin
      state_in = state_ff;
      slot_valid_in = slot_valid_ff;
      voice_clip_in = voice_clip_ff;
      voice_pos_in = voice_pos_ff;
      voice_gain_in = voice_gain_ff;
      voice_loops_in = voice_loops_ff;
      cursor_in = cursor_ff;
      load_slot_in = load_slot_ff;
      load_count_in = load_count_ff;
      load_failed_in = load_failed_ff;
      vidx_in = vidx_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      scaled_in = scaled_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      rsp_mixed_in = rsp_mixed_ff;
      rsp_id_in = rsp_id_ff;
      rsp_ok_in = rsp_ok_ff;
      st_we = 1'b0;
      len_we = 1'b0;
      slot_eff = load_slot_ff;
      slot_m1 = '0;
      cnt_eff = load_count_ff;
      fail_eff = load_failed_ff;
      st_waddr = '0;
      st_wdata = req_channel.sample;
      len_waddr = '0;
      len_wdata = '0;
      st_raddr = ADDR_W'(ADDR_W'(voice_clip_ff[vidx_ff] - CLIP_W'(1)) * ADDR_W'(MAX_FRAMES))
                 + ADDR_W'(voice_pos_ff[vidx_ff][FRAME_W-1:0]);
      len_raddr = SLOT_W'(voice_clip_ff[vidx_ff] - CLIP_W'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_mixed_in = '0;
               rsp_id_in = '0;
               rsp_ok_in = 1'b0;
               case (op_type'(req_channel.operation))
                  OP_MIX: begin
                     rsp_valid_in = 1'b0;
                     acc_in = ACC_W'(req_channel.sample);
                     vidx_in = '0;
                     state_in = ST_READ;
                  end
                  OP_LOAD: begin
                     if (load_slot_ff == '0 && !load_failed_ff) begin
                        cnt_eff = '0;
                        if (free_found) begin
                           slot_eff = CLIP_W'(free_idx) + CLIP_W'(1);
                        end else begin
                           fail_eff = 1'b1;
                        end
                     end
                     if (!fail_eff && int'(cnt_eff) >= MAX_FRAMES) begin
                        fail_eff = 1'b1;
                     end
                     slot_m1 = slot_eff - CLIP_W'(1);
                     if (!fail_eff) begin
                        st_we = 1'b1;
                        st_waddr = ADDR_W'(ADDR_W'(slot_m1[SLOT_W-1:0]) * ADDR_W'(MAX_FRAMES))
                                   + ADDR_W'(cnt_eff[FRAME_W-1:0]);
                        cnt_eff = cnt_eff + LEN_W'(1);
                        rsp_ok_in = 1'b1;
                     end
                     if (req_channel.last) begin
                        if (!fail_eff) begin
                           len_we = 1'b1;
                           len_waddr = slot_m1[SLOT_W-1:0];
                           len_wdata = cnt_eff;
                           slot_valid_in[slot_m1[SLOT_W-1:0]] = 1'b1;
                           rsp_id_in = slot_eff;
                        end
                        load_slot_in = '0;
                        load_count_in = '0;
                        load_failed_in = 1'b0;
                     end else begin
                        load_slot_in = slot_eff;
                        load_count_in = cnt_eff;
                        load_failed_in = fail_eff;
                     end
                  end
                  OP_UNREGISTER: begin
                     if (clip_ok(req_channel.clip, slot_valid_ff)) begin
                        for (int v = 0; v < VOICES; v++) begin
                           if (voice_clip_ff[v] == req_channel.clip) begin
                              voice_clip_in[v] = '0;
                              voice_pos_in[v] = '0;
                              voice_gain_in[v] = '0;
                              voice_loops_in[v] = 1'b0;
                           end
                        end
                        slot_valid_in[cm1[SLOT_W-1:0]] = 1'b0;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  OP_PLAY, OP_PLAY_LOOP: begin
                     if (clip_ok(req_channel.clip, slot_valid_ff)) begin
                        rsp_ok_in = 1'b1;
                        if (op_type'(req_channel.operation) == OP_PLAY_LOOP && loop_hit) begin
                           voice_gain_in[loop_v] = gain_c;
                        end else begin
                           if (!voice_free) begin
                              cursor_in = (int'(cursor_ff) == VOICES - 1)
                                          ? '0 : cursor_ff + VOICE_W'(1);
                           end
                           voice_clip_in[take_v] = req_channel.clip;
                           voice_pos_in[take_v] = '0;
                           voice_gain_in[take_v] = gain_c;
                           voice_loops_in[take_v] =
                              (op_type'(req_channel.operation) == OP_PLAY_LOOP);
                        end
                     end
                  end
                  OP_STOP_LOOP: begin
                     for (int v = 0; v < VOICES; v++) begin
                        if (voice_clip_ff[v] == req_channel.clip && voice_loops_ff[v]) begin
                           voice_clip_in[v] = '0;
                           voice_pos_in[v] = '0;
                           voice_gain_in[v] = '0;
                           voice_loops_in[v] = 1'b0;
                        end
                     end
                     rsp_ok_in = 1'b1;
                  end
                  OP_STOP_ALL: begin
                     for (int v = 0; v < VOICES; v++) begin
                        voice_clip_in[v] = '0;
                        voice_pos_in[v] = '0;
                        voice_gain_in[v] = '0;
                     end
                     voice_loops_in = '0;
                     cursor_in = '0;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (voice_clip_ff[vidx_ff] != '0 && clip_ok(voice_clip_ff[vidx_ff], slot_valid_ff)) begin
               state_in = ST_CHECK;
            end else begin
               voice_clip_in[vidx_ff] = '0;
               voice_pos_in[vidx_ff] = '0;
               voice_gain_in[vidx_ff] = '0;
               voice_loops_in[vidx_ff] = 1'b0;
               if (int'(vidx_ff) == VOICES - 1) begin
                  state_in = ST_DONE;
               end else begin
                  vidx_in = vidx_ff + VOICE_W'(1);
               end
            end
         end
         ST_CHECK: begin
            if (voice_pos_ff[vidx_ff] >= len_rdata) begin
               voice_clip_in[vidx_ff] = '0;
               voice_pos_in[vidx_ff] = '0;
               voice_gain_in[vidx_ff] = '0;
               voice_loops_in[vidx_ff] = 1'b0;
               if (int'(vidx_ff) == VOICES - 1) begin
                  state_in = ST_DONE;
               end else begin
                  vidx_in = vidx_ff + VOICE_W'(1);
                  state_in = ST_READ;
               end
            end else begin
               prod_in = PROD_W'($signed(st_rdata) * $signed({1'b0, voice_gain_ff[vidx_ff]}));
               voice_pos_in[vidx_ff] = pos_next;
               if (pos_next >= len_rdata) begin
                  if (voice_loops_ff[vidx_ff]) begin
                     voice_pos_in[vidx_ff] = '0;
                  end else begin
                     voice_clip_in[vidx_ff] = '0;
                     voice_pos_in[vidx_ff] = '0;
                     voice_gain_in[vidx_ff] = '0;
                     voice_loops_in[vidx_ff] = 1'b0;
                  end
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            neg_in = prod_ff[PROD_W-1];
            scaled_in = (ABS_W+RECIP_W)'(prod_abs) * (ABS_W+RECIP_W)'(RECIP_100);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + quot_s;
            if (int'(vidx_ff) == VOICES - 1) begin
               state_in = ST_DONE;
            end else begin
               vidx_in = vidx_ff + VOICE_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = '0;
               rsp_ok_in = 1'b1;
               if (acc_ff > SAT_HI) begin
                  rsp_mixed_in = SMP_W'(SAT_HI);
               end else if (acc_ff < SAT_LO) begin
                  rsp_mixed_in = SMP_W'(SAT_LO);
               end else begin
                  rsp_mixed_in = SMP_W'(acc_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_valid_ff <= '0;
         for (int v = 0; v < VOICES; v++) begin
            voice_clip_ff[v] <= '0;
            voice_pos_ff[v] <= '0;
            voice_gain_ff[v] <= '0;
         end
         voice_loops_ff <= '0;
         cursor_ff <= '0;
         load_slot_ff <= '0;
         load_count_ff <= '0;
         load_failed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_valid_ff <= slot_valid_in;
         voice_clip_ff <= voice_clip_in;
         voice_pos_ff <= voice_pos_in;
         voice_gain_ff <= voice_gain_in;
         voice_loops_ff <= voice_loops_in;
         cursor_ff <= cursor_in;
         load_slot_ff <= load_slot_in;
         load_count_ff <= load_count_in;
         load_failed_ff <= load_failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff <= vidx_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      scaled_ff <= scaled_in;
      neg_ff <= neg_in;
      rsp_mixed_ff <= rsp_mixed_in;
      rsp_id_ff <= rsp_id_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.mixed = rsp_mixed_ff;
   assign rsp_channel.clip_id = rsp_id_ff;
   assign rsp_channel.ok = rsp_ok_ff;
endmodule

### hw/rtl/pvm_checker.sv
`timescale 1ns / 1ps
module pvm_checker import pvm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [OP_W-1:0]         req_operation,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [SMP_W-1:0] rsp_mixed,
   input logic [CLIP_W-1:0]       rsp_clip_id,
   input logic                    rsp_ok
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation != OP_MIX) |=> rsp_valid)
      else $error("non-mix request not answered next cycle");

   a_id_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_clip_id != '0) |-> rsp_ok)
      else $error("clip id without ok");

   a_mix_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mixed != '0) |-> rsp_ok && (rsp_clip_id == '0))
      else $error("mixed sample on non-mix response");
endmodule

bind pcm_voice_mixer pvm_checker u_pvm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_channel.valid),
   .req_ready(req_channel.ready),
   .req_operation(req_channel.operation),
   .rsp_valid(rsp_channel.valid),
   .rsp_ready(rsp_channel.ready),
   .rsp_mixed(rsp_channel.mixed),
   .rsp_clip_id(rsp_channel.clip_id),
   .rsp_ok(rsp_channel.ok)
);

### tb/pvm_mixer_checker.sv
`timescale 1ns / 1ps
module pvm_mixer_checker import pvm_pkg::*; (
   input  logic clock,
   input  logic reset,
   pvm_req_if   req_mon,
   pvm_rsp_if   rsp_mon,
   output int   errors,
   output int   pending
);

   typedef struct packed {
      logic signed [SMP_W-1:0] mixed;
      logic [CLIP_W-1:0]       clip_id;
      logic                    ok;
   } mix_rsp_t;

   logic signed [SMP_W-1:0] sample_mem [STORE_DEPTH];
   int clip_len [CLIP_SLOTS];
   int voice_clip [VOICES];
   int voice_pos [VOICES];
   int voice_gain [VOICES];
   bit voice_loops [VOICES];
   int steal_ptr;
   int load_slot;
   int load_count;
   bit load_failed;

   mix_rsp_t rsp_expected [$];

   function automatic bit clip_ok(int c);
      return c >= 1 && c <= CLIP_SLOTS && clip_len[c-1] != 0;
   endfunction

   function automatic void voice_clear(int v);
      voice_clip[v]  = 0;
      voice_pos[v]   = 0;
      voice_gain[v]  = 0;
      voice_loops[v] = 0;
   endfunction

   function automatic int voice_take();
      int v;
      for (v = 0; v < VOICES; v++) begin
         if (voice_clip[v] == 0) return v;
      end
      v = steal_ptr % VOICES;
      steal_ptr = (v + 1) % VOICES;
      return v;
   endfunction

   function automatic void mixer_clear();
      for (int i = 0; i < CLIP_SLOTS; i++) clip_len[i] = 0;
      for (int v = 0; v < VOICES; v++) voice_clear(v);
      steal_ptr   = 0;
      load_slot   = 0;
      load_count  = 0;
      load_failed = 0;
   endfunction

   task automatic mixer_step(input op_type op, input logic [CLIP_W-1:0] clip_in,
                             input logic [GAIN_W-1:0] gain_in,
                             input logic signed [SMP_W-1:0] smp, input logic last,
                             output mix_rsp_t r);
      int acc, s_v, g_v, c, len, slot, v;
      int clip;
      logic [GAIN_W-1:0] g;
      bit found;
      r    = '0;
      clip = int'(clip_in);
      g    = (gain_in > GAIN_MAX) ? GAIN_MAX : gain_in;
      case (op)
         OP_MIX: begin
            acc = int'(smp);
            for (v = 0; v < VOICES; v++) begin
               c = voice_clip[v];
               if (c == 0) continue;
               if (!clip_ok(c) || voice_pos[v] >= clip_len[c-1]) begin
                  voice_clear(v);
                  continue;
               end
               len = clip_len[c-1];
               s_v = int'(sample_mem[(c - 1) * MAX_FRAMES + voice_pos[v]]);
               g_v = voice_gain[v];
               acc += (s_v * g_v) / 100;
               voice_pos[v]++;
               if (voice_pos[v] >= len) begin
                  if (voice_loops[v]) voice_pos[v] = 0;
                  else voice_clear(v);
               end
            end
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            r.mixed = acc[SMP_W-1:0];
            r.ok    = 1'b1;
         end
         OP_LOAD: begin
            if (load_slot == 0 && !load_failed) begin
               slot = -1;
               for (int i = 0; i < CLIP_SLOTS; i++) begin
                  if (clip_len[i] == 0) begin
                     slot = i;
                     break;
                  end
               end
               if (slot < 0) load_failed = 1;
               else begin
                  load_slot  = slot + 1;
                  load_count = 0;
               end
            end
            if (!load_failed && load_count >= MAX_FRAMES) load_failed = 1;
            if (!load_failed) begin
               sample_mem[(load_slot - 1) * MAX_FRAMES + load_count] = smp;
               load_count++;
               r.ok = 1'b1;
            end
            if (last) begin
               if (!load_failed) begin
                  clip_len[load_slot-1] = load_count;
                  r.clip_id = CLIP_W'(load_slot);
               end
               load_slot   = 0;
               load_count  = 0;
               load_failed = 0;
            end
         end
         OP_UNREGISTER: begin
            if (clip_ok(clip)) begin
               for (v = 0; v < VOICES; v++) begin
                  if (voice_clip[v] == clip) voice_clear(v);
               end
               clip_len[clip-1] = 0;
               r.ok = 1'b1;
            end
         end
         OP_PLAY, OP_PLAY_LOOP: begin
            if (clip_ok(clip)) begin
               r.ok  = 1'b1;
               found = 0;
               if (op == OP_PLAY_LOOP) begin
                  for (v = 0; v < VOICES; v++) begin
                     if (voice_clip[v] == clip && voice_loops[v]) begin
                        voice_gain[v] = int'(g);
                        found = 1;
                        break;
                     end
                  end
               end
               if (!found) begin
                  v = voice_take();
                  voice_clip[v]  = clip;
                  voice_pos[v]   = 0;
                  voice_gain[v]  = int'(g);
                  voice_loops[v] = (op == OP_PLAY_LOOP);
               end
            end
         end
         OP_STOP_LOOP: begin
            for (v = 0; v < VOICES; v++) begin
               if (voice_clip[v] == clip && voice_loops[v]) voice_clear(v);
            end
            r.ok = 1'b1;
         end
         OP_STOP_ALL: begin
            for (v = 0; v < VOICES; v++) voice_clear(v);
            steal_ptr = 0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      mix_rsp_t want;
      mix_rsp_t got;
      if (reset) begin
         mixer_clear();
         rsp_expected.delete();
         errors = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.mixed, rsp_mon.clip_id, rsp_mon.ok};
            if (rsp_expected.size() == 0) begin
               errors++;
               $display("%0t unexpected response: expected none, got mixed %0d clip_id %0d ok %0d",
                        $time, got.mixed, got.clip_id, got.ok);
            end else begin
               want = rsp_expected.pop_front();
               if (got.mixed !== want.mixed) begin
                  errors++;
                  $display("%0t mixed: expected %0d, got %0d", $time, want.mixed, got.mixed);
               end
               if (got.clip_id !== want.clip_id) begin
                  errors++;
                  $display("%0t clip_id: expected %0d, got %0d", $time, want.clip_id,
                           got.clip_id);
               end
               if (got.ok !== want.ok) begin
                  errors++;
                  $display("%0t ok: expected %0d, got %0d", $time, want.ok, got.ok);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            mixer_step(op_type'(req_mon.operation), req_mon.clip, req_mon.gain,
                       req_mon.sample, req_mon.last, want);
            rsp_expected.push_back(want);
         end
      end
      pending = rsp_expected.size();
   end

endmodule

### tb/tb_pcm_voice_mixer.sv
`timescale 1ns / 1ps
module tb_pcm_voice_mixer;
   import pvm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 600;

   logic clock;
   logic reset;
   int   cycles;
   int   errors;
   int   pending;
   int   burst_left;
   int   requests_sent;
   int   rx_cycles;
   bit   rx_held;

   pvm_req_if req_ch ();
   pvm_rsp_if rsp_ch ();

   pcm_voice_mixer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   pvm_mixer_checker u_check (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_ch),
      .rsp_mon (rsp_ch),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAIL pcm_voice_mixer");
            $finish;
         end
      end
   end

   function automatic logic signed [SMP_W-1:0] pick_sample();
      case ($urandom % 8)
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   function automatic logic [CLIP_W-1:0] pick_clip();
      if ($urandom % 8 == 0) return CLIP_W'($urandom_range(0, 127));
      return CLIP_W'($urandom_range(1, 12));
   endfunction

   task automatic send_req(input op_type op, input logic [CLIP_W-1:0] clip,
                           input logic [GAIN_W-1:0] gain,
                           input logic signed [SMP_W-1:0] smp, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom % 4 != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.clip      <= clip;
      req_ch.gain      <= gain;
      req_ch.sample    <= smp;
      req_ch.last      <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_noise(input op_type op);
      send_req(op, pick_clip(), GAIN_W'($urandom), pick_sample(), 1'($urandom));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   task automatic load_clip(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom % 12 == 0) send_noise(OP_MIX);
         send_req(OP_LOAD, CLIP_W'($urandom), GAIN_W'($urandom), pick_sample(), i == len - 1);
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      rx_cycles    = 0;
      rx_held      = 0;
      @(negedge reset);
      forever begin
         int mode;
         int span;
         mode = $urandom % 3;
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            rx_cycles++;
            if (!rx_held && rx_cycles >= 1500) begin
               rx_held = 1;
               rsp_ch.ready <= 1'b0;
               repeat (600) @(posedge clock);
               rx_cycles += 600;
            end else begin
               case (mode)
                  0:       rsp_ch.ready <= 1'b1;
                  1:       rsp_ch.ready <= 1'($urandom % 2);
                  default: rsp_ch.ready <= ($urandom % 4 == 0);
               endcase
            end
         end
      end
   end

   initial begin
      int  kind;
      bit  filled;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_NONE;
      req_ch.clip      = '0;
      req_ch.gain      = '0;
      req_ch.sample    = '0;
      req_ch.last      = 1'b0;
      burst_left       = 0;
      requests_sent    = 0;
      filled           = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(OP_MIX, 0, 0, 16'sh7fff, 0);
      send_req(OP_MIX, 7'h7f, 8'hff, 16'sh8000, 1);
      send_req(OP_LOAD, 0, 0, 16'sh7fff, 0);
      send_req(OP_LOAD, 0, 0, 16'sh8000, 0);
      send_req(OP_LOAD, 0, 0, 16'sh0001, 1);
      send_req(OP_LOAD, 0, 0, -16'sd1, 1);
      send_req(OP_PLAY, 1, 8'hff, 0, 0);
      send_req(OP_PLAY_LOOP, 2, 0, 0, 0);
      send_req(OP_PLAY_LOOP, 2, 150, 0, 0);
      send_req(OP_PLAY, 0, 100, 0, 0);
      send_req(OP_PLAY, 64, 100, 0, 0);
      send_req(OP_PLAY_LOOP, 100, 100, 0, 0);
      send_req(OP_UNREGISTER, 7'h7f, 0, 0, 0);
      send_req(OP_MIX, 0, 0, 16'sh7fff, 0);
      send_req(OP_MIX, 0, 0, 16'sh8000, 0);
      send_req(OP_MIX, 0, 0, 16'sh7fff, 0);
      send_req(OP_MIX, 0, 0, 0, 0);
      send_req(OP_STOP_LOOP, 2, 0, 0, 0);
      send_req(OP_PLAY_LOOP, 1, 200, 0, 0);
      send_req(OP_STOP_ALL, 0, 0, 0, 0);
      send_req(OP_UNREGISTER, 1, 0, 0, 0);
      send_req(OP_UNREGISTER, 1, 0, 0, 0);
      send_req(OP_NONE, 7'h7f, 8'hff, -16'sd1, 1);
      drain();

      while (requests_sent < RANDOM_ITEMS) begin
         if (!filled && requests_sent > 300) begin
            filled = 1;
            drain();
            repeat (CLIP_SLOTS + 4) load_clip(1);
            send_noise(OP_MIX);
            for (int c = 1; c <= CLIP_SLOTS; c += 2) begin
               send_req(OP_UNREGISTER, CLIP_W'(c), 0, 0, 0);
            end
            load_clip(MAX_FRAMES + 1);
            load_clip(3);
         end
         kind = $urandom % 16;
         case (kind)
            0, 1, 2: load_clip(($urandom % 8 == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6));
            3, 4:    send_req(OP_PLAY, pick_clip(), GAIN_W'($urandom), pick_sample(),
                              1'($urandom));
            5:       send_req(OP_PLAY_LOOP, pick_clip(), GAIN_W'($urandom), pick_sample(),
                              1'($urandom));
            6, 7, 8, 9, 10: repeat ($urandom_range(1, 6)) send_noise(OP_MIX);
            11:      send_noise(OP_UNREGISTER);
            12:      send_noise(OP_STOP_LOOP);
            13:      send_noise(($urandom % 3 == 0) ? OP_STOP_ALL : OP_MIX);
            14:      send_noise(OP_NONE);
            default: repeat (VOICES + 1) send_noise(($urandom % 2) ? OP_PLAY : OP_PLAY_LOOP);
         endcase
         if ($urandom % 60 == 0) drain();
      end

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASS pcm_voice_mixer");
      end else begin
         $display("FAIL pcm_voice_mixer");
      end
      $finish;
   end

endmodule

### pcm_voice_mixer.f
hw/rtl/pvm_pkg.sv
hw/rtl/pvm_if.sv
hw/rtl/pvm_ram.sv
hw/rtl/pcm_voice_mixer.sv
hw/rtl/pvm_checker.sv
tb/pvm_mixer_checker.sv
tb/tb_pcm_voice_mixer.sv
